@@ hdl/rsmp_pkg.sv @@
package rsmp_pkg;

   // Default sizes
   localparam int QUEUE_DEPTH_DEF = 4096;
   localparam int MAX_REQUEST_DEF = 64;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int FRAMES_W  = 7;
   localparam int RATE_W    = 18;
   localparam int COUNT_W   = 13;
   localparam int TOTAL_W   = 32;
   localparam int POS_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0]   Q_ONE           = 32'h0001_0000;
   localparam logic [RATE_W-1:0]  SOURCE_RATE_RST = 18'd48000;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 32'hFFFF_FFFF;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_RATE = 2'd0,
      REG_OUTPUT_RATE = 2'd1
   } csr_reg_type;

   // One classified command from the front queue
   typedef struct packed {
      logic                       pull;
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic [FRAMES_W-1:0]        frames;
   } cmd_type;

   // Step ratio status from the rate unit
   typedef struct packed {
      logic             busy;
      logic             pass;
      logic [POS_W-1:0] step;
   } ratio_type;

endpackage

@@ hdl/rsmp_ram.sv @@
module rsmp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rsmp_front.sv @@
module rsmp_front #(
   parameter int MAX_REQUEST = rsmp_pkg::MAX_REQUEST_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_action,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] req_left_in,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] req_right_in,
   input  logic [rsmp_pkg::FRAMES_W-1:0]        req_request_frames,
   output logic                                 cmd_valid,
   output rsmp_pkg::cmd_type                    cmd,
   input  logic                                 cmd_pop
);
   import rsmp_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    new_cmd;
   logic       accept;
   logic       keep;

   // Classify the beat: clip the frame count, drop empty pulls
   always_comb begin
      new_cmd.pull   = req_action;
      new_cmd.left   = req_left_in;
      new_cmd.right  = req_right_in;
      new_cmd.frames = (req_request_frames > FRAMES_W'(MAX_REQUEST)) ?
                       FRAMES_W'(MAX_REQUEST) : req_request_frames;
      accept = push && !full;
      keep   = accept && !(req_action && (req_request_frames == '0));
   end

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = keep ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(keep) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued commands
   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

endmodule

@@ hdl/rsmp_div.sv @@
module rsmp_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rsmp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsmp_pkg::RATE_W-1:0]         csr_wdata,
   output rsmp_pkg::ratio_type                 ratio
);
   import rsmp_pkg::*;

   localparam int DVD_W = RATE_W + 16;
   localparam int CNT_W = $clog2(DVD_W + 1);

   typedef enum logic [2:0] {
      DV_IDLE = 3'b001,
      DV_LOAD = 3'b010,
      DV_RUN  = 3'b100
   } dv_state_type;

   dv_state_type      state_ff, state_in;
   logic [RATE_W-1:0] src_ff, src_in;
   logic [RATE_W-1:0] out_ff, out_in;
   logic [POS_W-1:0]  step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W:0]   trial;
   logic              ge;
   logic              wr;

   assign wr = csr_valid && csr_ready;

   always_comb begin
      state_in = state_ff;
      src_in   = src_ff;
      out_in   = out_ff;
      step_in  = step_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      trial    = {rem_ff, dvd_ff[DVD_W-1]};
      ge       = (trial >= {1'b0, out_ff});
      unique case (state_ff)
         DV_IDLE: begin
            // Take a rate write and schedule the ratio update
            if (wr && (csr_index == REG_SOURCE_RATE)) begin
               src_in   = csr_wdata;
               state_in = DV_LOAD;
            end else if (wr && (csr_index == REG_OUTPUT_RATE)) begin
               out_in   = csr_wdata;
               state_in = DV_LOAD;
            end
         end
         DV_LOAD: begin
            if (out_ff == '0) begin
               step_in  = Q_ONE;
               state_in = DV_IDLE;
            end else begin
               dvd_in   = {src_ff, 16'h0000};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            // One quotient bit a cycle
            rem_in = ge ? RATE_W'(trial - {1'b0, out_ff}) : RATE_W'(trial);
            dvd_in = {dvd_ff[DVD_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               step_in  = (dvd_in[DVD_W-1:POS_W] != '0) ? TOTAL_MAX : dvd_in[POS_W-1:0];
               state_in = DV_IDLE;
            end
         end
         default: state_in = DV_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         src_ff   <= SOURCE_RATE_RST;
         out_ff   <= '0;
         step_ff  <= Q_ONE;
      end else begin
         state_ff <= state_in;
         src_ff   <= src_in;
         out_ff   <= out_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign csr_ready  = (state_ff == DV_IDLE);
   assign ratio.busy = (state_ff != DV_IDLE);
   assign ratio.pass = (out_ff == '0) || (out_ff == src_ff);
   assign ratio.step = step_ff;

endmodule

@@ hdl/rsmp_back.sv @@
module rsmp_back #(
   parameter int QUEUE_DEPTH = rsmp_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_REQUEST = rsmp_pkg::MAX_REQUEST_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  rsmp_pkg::cmd_type                    cmd,
   output logic                                 cmd_pop,
   input  rsmp_pkg::ratio_type                  ratio,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_right_out,
   output logic                                 rsp_from_queue,
   output logic                                 rsp_last_frame,
   output logic [rsmp_pkg::COUNT_W-1:0]         rsp_queued_count,
   output logic [rsmp_pkg::TOTAL_W-1:0]         rsp_underruns,
   output logic [rsmp_pkg::TOTAL_W-1:0]         rsp_overruns
);
   import rsmp_pkg::*;

   localparam int PW    = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SW    = CW + 1;
   localparam int KW    = $clog2(MAX_REQUEST + 1);
   localparam int BW    = MAX_REQUEST > 1 ? $clog2(MAX_REQUEST) : 1;
   localparam int WORD  = 2 * SAMPLE_W;
   localparam int BUF_W = WORD + 1;
   localparam int PROD_W = 2 * (SAMPLE_W + 1);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RD0   = 9'b000000010,
      ST_RD1   = 9'b000000100,
      ST_MUL   = 9'b000001000,
      ST_WR    = 9'b000010000,
      ST_COMMIT= 9'b000100000,
      ST_DR_RD = 9'b001000000,
      ST_DR_LD = 9'b010000000,
      ST_DR_WT = 9'b100000000
   } st_type;

   st_type                   state_ff, state_in;
   logic [PW-1:0]            rp_ff, rp_in;
   logic [CW-1:0]            fill_ff, fill_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic [TOTAL_W-1:0]       ur_ff, ur_in;
   logic [TOTAL_W-1:0]       ov_ff, ov_in;
   logic                     pt_ff, pt_in;
   logic [KW-1:0]            n_ff, n_in;
   logic [KW-1:0]            k_ff, k_in;
   logic                     v0_ff, v0_in;
   logic                     v1_ff, v1_in;
   logic [WORD-1:0]          w0_ff, w0_in;
   logic signed [PROD_W-1:0] pl_ff, pr_ff;
   logic                     ovalid_ff, ovalid_in;
   logic                     olast_ff, olast_in;
   logic [BUF_W-1:0]         obuf_ff;

   logic             st_wr_en;
   logic [PW-1:0]    st_wr_addr;
   logic [PW-1:0]    st_rd_addr;
   logic [WORD-1:0]  st_rd_data;
   logic             bf_wr_en;
   logic [BUF_W-1:0] bf_wr_data;
   logic [BUF_W-1:0] bf_rd_data;

   logic [15:0]              base;
   logic [16:0]              base1;
   logic [15:0]              frac;
   logic                     v0_now, v1_now;
   logic [WORD-1:0]          w1;
   logic signed [SAMPLE_W:0] dl, dr, fs;
   logic signed [PROD_W-1:0] vl, vr;
   logic [SAMPLE_W-1:0]      ol, orr;
   logic [POS_W:0]           np;
   logic [31:0]              take32, used32;
   logic                     last_k;

   // Ring slot of an offset from the read pointer
   function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] p, input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(p) + SW'(off);
      if (s >= SW'(QUEUE_DEPTH)) begin
         s = s - SW'(QUEUE_DEPTH);
      end
      return PW'(s);
   endfunction

   // Base frame and fraction of the current output frame
   always_comb begin
      base   = pt_ff ? 16'(k_ff) : pos_ff[POS_W-1:16];
      frac   = pt_ff ? 16'h0000 : pos_ff[15:0];
      base1  = {1'b0, base} + 17'd1;
      v0_now = (32'(base) < 32'(fill_ff));
      v1_now = (32'(base1) < 32'(fill_ff));
      w1     = v1_ff ? st_rd_data : w0_ff;
      fs     = $signed({1'b0, frac});
      dl     = $signed({w1[SAMPLE_W-1], w1[SAMPLE_W-1:0]}) -
               $signed({w0_ff[SAMPLE_W-1], w0_ff[SAMPLE_W-1:0]});
      dr     = $signed({w1[WORD-1], w1[WORD-1:SAMPLE_W]}) -
               $signed({w0_ff[WORD-1], w0_ff[WORD-1:SAMPLE_W]});
      // Truncate toward zero: bias negative sums before the shift
      vl     = $signed({{2{w0_ff[SAMPLE_W-1]}}, w0_ff[SAMPLE_W-1:0], 16'h0000}) + pl_ff;
      vr     = $signed({{2{w0_ff[WORD-1]}}, w0_ff[WORD-1:SAMPLE_W], 16'h0000}) + pr_ff;
      vl     = vl + (vl[PROD_W-1] ? PROD_W'(16'hFFFF) : '0);
      vr     = vr + (vr[PROD_W-1] ? PROD_W'(16'hFFFF) : '0);
      ol     = vl[31:16];
      orr    = vr[31:16];
      np     = {1'b0, pos_ff} + {1'b0, ratio.step};
      take32 = (32'(n_ff) < 32'(fill_ff)) ? 32'(n_ff) : 32'(fill_ff);
      used32 = (32'(pos_ff[POS_W-1:16]) > 32'(fill_ff)) ?
               32'(fill_ff) : 32'(pos_ff[POS_W-1:16]);
      last_k = (k_ff == n_ff - 1'b1);
   end

   always_comb begin
      state_in  = state_ff;
      rp_in     = rp_ff;
      fill_in   = fill_ff;
      pos_in    = pos_ff;
      ur_in     = ur_ff;
      ov_in     = ov_ff;
      pt_in     = pt_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      v0_in     = v0_ff;
      v1_in     = v1_ff;
      w0_in     = w0_ff;
      ovalid_in = ovalid_ff;
      olast_in  = olast_ff;
      cmd_pop   = 1'b0;
      st_wr_en  = 1'b0;
      st_wr_addr = slot_of(rp_ff, fill_ff);
      st_rd_addr = slot_of(rp_ff, CW'(base));
      bf_wr_en  = 1'b0;
      bf_wr_data = {v0_ff, orr, ol};
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && !ratio.busy) begin
               cmd_pop = 1'b1;
               if (!cmd.pull) begin
                  // Store the frame, drop the oldest when full
                  st_wr_en = 1'b1;
                  if (fill_ff == CW'(QUEUE_DEPTH)) begin
                     st_wr_addr = rp_ff;
                     rp_in      = slot_of(rp_ff, CW'(1));
                     ov_in      = (ov_ff == TOTAL_MAX) ? ov_ff : ov_ff + 1'b1;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
               end else begin
                  pt_in    = ratio.pass;
                  n_in     = KW'(cmd.frames);
                  k_in     = '0;
                  state_in = ST_RD0;
               end
            end
         end
         ST_RD0: begin
            v0_in    = v0_now;
            state_in = ST_RD1;
         end
         ST_RD1: begin
            w0_in      = v0_ff ? st_rd_data : '0;
            v1_in      = v1_now;
            st_rd_addr = slot_of(rp_ff, CW'(base1));
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_WR;
         end
         ST_WR: begin
            // Keep the frame, advance the position
            bf_wr_en = 1'b1;
            k_in     = k_ff + 1'b1;
            if (!pt_ff) begin
               pos_in = np[POS_W] ? TOTAL_MAX : np[POS_W-1:0];
            end
            state_in = last_k ? ST_COMMIT : ST_RD0;
         end
         ST_COMMIT: begin
            // Consume the frames passed
            if (pt_ff) begin
               rp_in   = slot_of(rp_ff, CW'(take32));
               fill_in = fill_ff - CW'(take32);
               if (32'(fill_ff) < 32'(n_ff)) begin
                  ur_in = (ur_ff == TOTAL_MAX) ? ur_ff : ur_ff + 1'b1;
               end
            end else if (fill_ff != '0) begin
               rp_in   = slot_of(rp_ff, CW'(used32));
               fill_in = fill_ff - CW'(used32);
               pos_in  = pos_ff - {used32[15:0], 16'h0000};
            end else begin
               pos_in = '0;
               ur_in  = (ur_ff == TOTAL_MAX) ? ur_ff : ur_ff + 1'b1;
            end
            k_in     = '0;
            state_in = ST_DR_RD;
         end
         ST_DR_RD: begin
            state_in = ST_DR_LD;
         end
         ST_DR_LD: begin
            ovalid_in = 1'b1;
            olast_in  = last_k;
            state_in  = ST_DR_WT;
         end
         ST_DR_WT: begin
            if (pop) begin
               ovalid_in = 1'b0;
               if (olast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_DR_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rp_ff     <= '0;
         fill_ff   <= '0;
         pos_ff    <= '0;
         ur_ff     <= '0;
         ov_ff     <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rp_ff     <= rp_in;
         fill_ff   <= fill_in;
         pos_ff    <= pos_in;
         ur_ff     <= ur_in;
         ov_ff     <= ov_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      pt_ff    <= pt_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      v0_ff    <= v0_in;
      v1_ff    <= v1_in;
      w0_ff    <= w0_in;
      olast_ff <= olast_in;
      pl_ff    <= dl * fs;
      pr_ff    <= dr * fs;
      if (state_ff == ST_DR_LD) begin
         obuf_ff <= bf_rd_data;
      end
   end

   rsmp_ram #(.WIDTH(WORD), .DEPTH(QUEUE_DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data ({cmd.right, cmd.left}),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   rsmp_ram #(.WIDTH(BUF_W), .DEPTH(MAX_REQUEST)) u_outbuf (
      .clock   (clock),
      .wr_en   (bf_wr_en),
      .wr_addr (BW'(k_ff)),
      .wr_data (bf_wr_data),
      .rd_addr (BW'(k_ff)),
      .rd_data (bf_rd_data)
   );

   assign empty            = !ovalid_ff;
   assign rsp_left_out     = obuf_ff[SAMPLE_W-1:0];
   assign rsp_right_out    = obuf_ff[WORD-1:SAMPLE_W];
   assign rsp_from_queue   = obuf_ff[WORD];
   assign rsp_last_frame   = olast_ff;
   assign rsp_queued_count = COUNT_W'(fill_ff);
   assign rsp_underruns    = ur_ff;
   assign rsp_overruns     = ov_ff;

endmodule

@@ hdl/stereo_frame_fifo_resampler.sv @@
// Channel   Handshake                 Payload
// request   push / full               req_action, req_left_in, req_right_in,
//                                     req_request_frames
// response  empty / pop               rsp_left_out .. rsp_overruns
// csr       csr_valid / csr_ready     csr_index, csr_wdata
//
// A push is stored by the back end from its idle state; a pull of n frames steps each
// frame through the frame store read port and the interpolation multiplier, then
// commits once, then drains each frame from the result buffer.
// A rate write holds csr_ready low while the ratio divider runs, or only through
// the load state when output_rate is zero.
// Reset is synchronous; the frame store is not cleared. A two-entry command queue
// keeps push accepting while the back end is busy or a beat waits on pop.
module stereo_frame_fifo_resampler #(
   parameter int QUEUE_DEPTH = rsmp_pkg::QUEUE_DEPTH_DEF,
   parameter int MAX_REQUEST = rsmp_pkg::MAX_REQUEST_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_action,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] req_left_in,
   input  logic signed [rsmp_pkg::SAMPLE_W-1:0] req_right_in,
   input  logic [rsmp_pkg::FRAMES_W-1:0]        req_request_frames,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_right_out,
   output logic                                 rsp_from_queue,
   output logic                                 rsp_last_frame,
   output logic [rsmp_pkg::COUNT_W-1:0]         rsp_queued_count,
   output logic [rsmp_pkg::TOTAL_W-1:0]         rsp_underruns,
   output logic [rsmp_pkg::TOTAL_W-1:0]         rsp_overruns,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rsmp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rsmp_pkg::RATE_W-1:0]          csr_wdata
);
   import rsmp_pkg::*;

   logic      cmd_valid;
   logic      cmd_pop;
   cmd_type   cmd;
   ratio_type ratio;

   rsmp_front #(.MAX_REQUEST(MAX_REQUEST)) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_action         (req_action),
      .req_left_in        (req_left_in),
      .req_right_in       (req_right_in),
      .req_request_frames (req_request_frames),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop)
   );

   rsmp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ratio     (ratio)
   );

   rsmp_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .MAX_REQUEST(MAX_REQUEST)) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop),
      .ratio            (ratio),
      .empty            (empty),
      .pop              (pop),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_from_queue   (rsp_from_queue),
      .rsp_last_frame   (rsp_last_frame),
      .rsp_queued_count (rsp_queued_count),
      .rsp_underruns    (rsp_underruns),
      .rsp_overruns     (rsp_overruns)
   );

endmodule

@@ hdl/rsmp_checker.sv @@
module rsmp_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 empty,
   input logic                                 pop,
   input logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_left_out,
   input logic signed [rsmp_pkg::SAMPLE_W-1:0] rsp_right_out,
   input logic                                 rsp_from_queue,
   input logic                                 csr_valid,
   input logic                                 csr_ready,
   input logic [rsmp_pkg::CSR_IDX_W-1:0]       csr_index
);
   import rsmp_pkg::*;

   // Nothing waits on the result side right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result present after reset");

   // A rate write starts the ratio update
   a_rate_busy: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready &&
       (csr_index == REG_SOURCE_RATE || csr_index == REG_OUTPUT_RATE)) |=> !csr_ready)
      else $error("rate write did not start ratio update");

   // Zero fill beats carry silence
   a_fill_silent: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_from_queue) |-> (rsp_left_out == '0 && rsp_right_out == '0))
      else $error("zero fill beat is not silent");

   // A stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_left_out) && $stable(rsp_right_out)))
      else $error("stalled result beat changed");

endmodule

bind stereo_frame_fifo_resampler rsmp_checker u_rsmp_checker (.*);

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rsmp_pkg::*;

   localparam int DEPTH    = QUEUE_DEPTH_DEF;
   localparam int MAX_REQ  = MAX_REQUEST_DEF;
   localparam bit ACT_PUSH = 1'b0;
   localparam bit ACT_PULL = 1'b1;

   typedef struct {
      bit                 action;
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic [6:0]         frames;
   } tb_cmd_type;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               from_queue;
      logic               last;
      logic [12:0]        queued;
      logic [31:0]        underruns;
      logic [31:0]        overruns;
   } frame_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic req_action = 1'b0;
   logic signed [15:0] req_left_in = '0;
   logic signed [15:0] req_right_in = '0;
   logic [6:0] req_request_frames = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic rsp_from_queue;
   logic rsp_last_frame;
   logic [12:0] rsp_queued_count;
   logic [31:0] rsp_underruns;
   logic [31:0] rsp_overruns;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = REG_SOURCE_RATE;
   logic [17:0] csr_wdata = '0;

   stereo_frame_fifo_resampler u_dut (.*);

   always #1 clock = ~clock;

   // Predictor state
   logic [31:0] ring [DEPTH];
   int unsigned rd_ptr, fill, pos, step, under_tot, over_tot, src_rate, out_rate;

   tb_cmd_type    pending_cmds[$];
   frame_out_type expected_frames[$];
   int            errors = 0;
   bit            hold_sender = 0;

   function automatic int unsigned sat_inc(int unsigned v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
   endfunction

   function automatic void recompute_step();
      longint unsigned q;
      if (out_rate == 0) begin
         step = 32'h1_0000;
      end else begin
         q = (longint'(src_rate) << 16) / out_rate;
         step = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
   endfunction

   function automatic int interpolate(int s0, int s1, int unsigned frac);
      longint v;
      v = longint'(s0) * 65536 + longint'(s1 - s0) * longint'(frac);
      return (v >= 0) ? int'(v / 65536) : -int'((-v) / 65536);
   endfunction

   // Work out the frames a command produces and advance the ring state
   function automatic void predict_frames(tb_cmd_type c);
      frame_out_type f[$];
      frame_out_type r;
      int unsigned n, take, base, frac, used;
      int l0, r0, l1, r1;
      longint unsigned np;
      logic [31:0] w;
      if (c.action == ACT_PUSH) begin
         if (fill >= DEPTH) begin
            rd_ptr = (rd_ptr + 1) % DEPTH;
            fill = DEPTH - 1;
            over_tot = sat_inc(over_tot);
         end
         ring[(rd_ptr + fill) % DEPTH] = {c.right, c.left};
         fill++;
         return;
      end
      n = c.frames;
      if (n == 0) return;
      if (n > MAX_REQ) n = MAX_REQ;
      if (out_rate == 0 || out_rate == src_rate) begin
         take = (n < fill) ? n : fill;
         for (int k = 0; k < n; k++) begin
            r = '{default: '0};
            if (k < take) begin
               w = ring[(rd_ptr + k) % DEPTH];
               r.left = w[15:0];
               r.right = w[31:16];
               r.from_queue = 1'b1;
            end
            f.push_back(r);
         end
         rd_ptr = (rd_ptr + take) % DEPTH;
         fill -= take;
         if (take < n) under_tot = sat_inc(under_tot);
      end else begin
         for (int k = 0; k < n; k++) begin
            r = '{default: '0};
            base = pos >> 16;
            frac = pos & 16'hFFFF;
            l0 = 0; r0 = 0;
            if (base < fill) begin
               w = ring[(rd_ptr + base) % DEPTH];
               l0 = $signed(w[15:0]);
               r0 = $signed(w[31:16]);
               r.from_queue = 1'b1;
            end
            if (longint'(base) + 1 < fill) begin
               w = ring[(rd_ptr + base + 1) % DEPTH];
               l1 = $signed(w[15:0]);
               r1 = $signed(w[31:16]);
            end else begin
               l1 = l0; r1 = r0;
            end
            r.left = 16'(interpolate(l0, l1, frac));
            r.right = 16'(interpolate(r0, r1, frac));
            np = longint'(pos) + step;
            pos = (np > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : np[31:0];
            f.push_back(r);
         end
         if (fill != 0) begin
            used = pos >> 16;
            if (used > fill) used = fill;
            rd_ptr = (rd_ptr + used) % DEPTH;
            fill -= used;
            pos -= used << 16;
         end else begin
            pos = 0;
            under_tot = sat_inc(under_tot);
         end
      end
      foreach (f[k]) begin
         f[k].last = (k == n - 1);
         f[k].queued = 13'(fill);
         f[k].underruns = under_tot;
         f[k].overruns = over_tot;
         expected_frames.push_back(f[k]);
      end
   endfunction

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: present one beat at a time, predict on acceptance
   int send_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_frames('{req_action, req_left_in, req_right_in, req_request_frames});
            void'(pending_cmds.pop_front());
            send_gap = gap_len();
         end
         // Hold a stalled beat; otherwise idle or present the next one
         if (!(push && full)) begin
            if (send_gap > 0 || pending_cmds.size() == 0 ||
                (hold_sender && expected_frames.size() != 0)) begin
               push <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               push <= 1'b1;
               req_action <= pending_cmds[0].action;
               req_left_in <= pending_cmds[0].left;
               req_right_in <= pending_cmds[0].right;
               req_request_frames <= pending_cmds[0].frames;
            end
         end
      end
   end

   // Monitor: check each popped beat against the oldest expectation
   int pop_gap = 0;
   always @(posedge clock) begin
      frame_out_type e;
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_frames.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat left=%0d", $time, rsp_left_out);
            end else begin
               e = expected_frames.pop_front();
               if (rsp_left_out !== e.left || rsp_right_out !== e.right ||
                   rsp_from_queue !== e.from_queue || rsp_last_frame !== e.last ||
                   rsp_queued_count !== e.queued || rsp_underruns !== e.underruns ||
                   rsp_overruns !== e.overruns) begin
                  errors++;
                  $display("%0t: exp l=%0d r=%0d q=%0b last=%0b cnt=%0d u=%0d o=%0d",
                           $time, e.left, e.right, e.from_queue, e.last, e.queued,
                           e.underruns, e.overruns);
                  $display("%0t: got l=%0d r=%0d q=%0b last=%0b cnt=%0d u=%0d o=%0d",
                           $time, rsp_left_out, rsp_right_out, rsp_from_queue,
                           rsp_last_frame, rsp_queued_count, rsp_underruns,
                           rsp_overruns);
               end
            end
            pop_gap = gap_len();
         end
         if (pop_gap > 0) begin
            pop <= 1'b0;
            pop_gap--;
         end else begin
            pop <= 1'b1;
         end
      end
   end

   task automatic write_reg(csr_reg_type idx, int unsigned val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 18'(val);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_SOURCE_RATE) src_rate = val; else out_rate = val;
      recompute_step();
   endtask

   // Wait until the block drains, plus slack for trailing commands
   task automatic drain();
      while (pending_cmds.size() != 0 || expected_frames.size() != 0 || push)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   function automatic void add_push(int l, int r);
      pending_cmds.push_back('{ACT_PUSH, 16'(l), 16'(r), 7'($urandom)});
   endfunction

   function automatic void add_pull(int n);
      pending_cmds.push_back('{ACT_PULL, 16'($urandom), 16'($urandom), 7'(n)});
   endfunction

   // Random phase: a random mix of pushes and pulls, some pulls zero or oversized
   task automatic random_phase(int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55)
            add_push($urandom, $urandom);
         else if ($urandom_range(0, 19) == 0)
            add_pull($urandom_range(0, 127));
         else
            add_pull($urandom_range(1, 12));
      end
      drain();
   endtask

   initial begin
      src_rate = 48000; out_rate = 0;
      rd_ptr = 0; fill = 0; pos = 0; under_tot = 0; over_tot = 0;
      recompute_step();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, underrun, zero and oversized requests
      add_pull(1);
      add_push(-32768, 32767);
      add_push(32767, -32768);
      add_push(0, -1);
      add_pull(2);
      add_pull(0);
      add_pull(3);
      for (int i = 0; i < 6; i++) add_push(i * 5000 - 15000, 12000 - i * 4000);
      add_pull(127);
      add_pull(64);
      drain();

      // Pause the sender until all results of each pull have arrived
      for (int i = 0; i < 10; i++) add_push($urandom, $urandom);
      add_pull(65);
      add_pull(64);
      hold_sender = 1;
      drain();
      hold_sender = 0;

      // Pass-through with equal rates
      write_reg(REG_OUTPUT_RATE, 48000);
      random_phase(30);
      // Downsample, upsample, extremes
      write_reg(REG_OUTPUT_RATE, 44100);
      random_phase(30);
      write_reg(REG_SOURCE_RATE, 8000);
      write_reg(REG_OUTPUT_RATE, 192000);
      random_phase(30);
      write_reg(REG_SOURCE_RATE, 192000);
      write_reg(REG_OUTPUT_RATE, 1);
      for (int i = 0; i < 5; i++) add_push($urandom, $urandom);
      add_pull(3);
      add_pull(2);
      drain();
      write_reg(REG_SOURCE_RATE, 1);
      write_reg(REG_OUTPUT_RATE, 3);
      random_phase(30);
      write_reg(REG_SOURCE_RATE, 262143);
      write_reg(REG_OUTPUT_RATE, 196607);
      random_phase(30);
      write_reg(REG_OUTPUT_RATE, 0);
      random_phase(30);

      if (errors == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("testbench: errors");
      $finish;
   end
endmodule
